### rtl/core/clhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clhp_pkg
// shared types, codes and the header literal for the content-length parser
// ----------------------------------------------------------------------------
package clhp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned CNT_W    = 5;

    // length of "Content-Length: "
    localparam logic [IDX_W-1:0] LIT_LEN    = 5'd16;
    localparam logic [CNT_W-1:0] MAX_DIGITS = 5'd19;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY  = 3'd0,
        ST_DONE  = 3'd1,
        ST_BAD   = 3'd2,
        ST_LONG  = 3'd3,
        ST_FAULT = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        PH_WS     = 4'b0001,
        PH_TEXT   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_LF     = 4'b1000
    } t_phase;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // one result word
    typedef struct packed {
        t_status            status;
        logic [LEN_W-1:0]   length;
    } t_result;

    function automatic logic [BYTE_W-1:0] lit_byte(input logic [3:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = "C";
            4'd1:    b = "o";
            4'd2:    b = "n";
            4'd3:    b = "t";
            4'd4:    b = "e";
            4'd5:    b = "n";
            4'd6:    b = "t";
            4'd7:    b = "-";
            4'd8:    b = "L";
            4'd9:    b = "e";
            4'd10:   b = "n";
            4'd11:   b = "g";
            4'd12:   b = "t";
            4'd13:   b = "h";
            4'd14:   b = ":";
            4'd15:   b = " ";
            default: b = " ";
        endcase
        return b;
    endfunction

endpackage

### rtl/core/clhp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clhp_in_reg
// input register stage, holds one byte until the parse step takes it
// ----------------------------------------------------------------------------
module clhp_in_reg
    import clhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_stream_fault,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_fault
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_fault;

    // free when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte  <= i_byte_in;
            r_fault <= i_stream_fault;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_fault = r_fault;

endmodule

### rtl/core/clhp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clhp_step
// parser state and the per-byte next-state / result logic
// ----------------------------------------------------------------------------
module clhp_step
    import clhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_fault,
    output t_result           o_res
);

    t_phase             r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [LEN_W-1:0]   r_acc,   n_acc;

    logic               is_ws;
    logic               is_digit;
    logic               text_chk;
    logic [LEN_W-1:0]   digit_val;
    logic [LEN_W-1:0]   acc_x10;

    assign is_ws     = i_byte inside {8'h20, [8'h09:8'h0D]};
    assign is_digit  = i_byte inside {[8'h30:8'h39]};
    assign digit_val = {{(LEN_W-4){1'b0}}, i_byte[3:0]};
    // times ten as shift and add
    assign acc_x10   = {r_acc[LEN_W-4:0], 3'b000} + {r_acc[LEN_W-2:0], 1'b0};

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        o_res.status = ST_BUSY;
        o_res.length = '0;
        text_chk     = 1'b0;

        if (i_fault) begin
            o_res.status = ST_FAULT;
        end else begin
            case (r_phase)
                PH_WS: begin
                    if (!is_ws) begin
                        text_chk = 1'b1;
                    end
                end
                PH_TEXT: begin
                    text_chk = 1'b1;
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        if (r_cnt >= MAX_DIGITS) begin
                            o_res.status = ST_LONG;
                        end else begin
                            n_cnt = r_cnt + 5'd1;
                            n_acc = acc_x10 + digit_val;
                        end
                    end else if (i_byte == CH_CR) begin
                        n_phase = PH_LF;
                    end else begin
                        o_res.status = ST_BAD;
                    end
                end
                PH_LF: begin
                    if (i_byte == CH_LF) begin
                        o_res.status = ST_DONE;
                        o_res.length = r_acc;
                    end else begin
                        o_res.status = ST_BAD;
                    end
                end
                default: begin
                    o_res.status = ST_BAD;
                end
            endcase

            if (text_chk) begin
                if (r_idx < LIT_LEN) begin
                    if (i_byte != lit_byte(r_idx[3:0])) begin
                        o_res.status = ST_BAD;
                    end else begin
                        n_phase = PH_TEXT;
                        n_idx   = r_idx + 5'd1;
                    end
                end else if (!is_digit) begin
                    o_res.status = ST_BAD;
                end else begin
                    n_phase = PH_DIGITS;
                    n_idx   = '0;
                    n_cnt   = 5'd1;
                    n_acc   = digit_val;
                end
            end
        end

        // any final status starts a fresh header
        if (o_res.status != ST_BUSY) begin
            n_phase = PH_WS;
            n_idx   = '0;
            n_cnt   = '0;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WS;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_acc   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
        end
    end

endmodule

### rtl/core/clhp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clhp_out_reg
// result register, holds one word until the receiver takes it
// ----------------------------------------------------------------------------
module clhp_out_reg
    import clhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_result             i_res,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_length
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_res.status;
    assign o_length = r_res.length;

endmodule

### rtl/core/content_length_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_length_header_parser_top
// byte-serial parser for a "Content-Length: <digits>\r\n" framing header
// ----------------------------------------------------------------------------
// usage
//   input channel: one header byte per word (i_byte_in) plus i_stream_fault,
//   handed over with i_valid / o_ready
//   output channel: exactly one result word per input word, o_status and
//   o_length, handed over with o_valid / i_ready
//   status: busy while the header is still in progress, done with the
//   length on the closing LF, or bad format / too many digits / stream fault;
//   every final status returns the parser to whitespace skipping
//   path: an accepted input word is held in the input register, then one
//   parse step writes its result into the result register
//   throughput: one word per cycle while i_ready does not stall the output;
//   the parse step's longest path is the times-ten accumulate (two chained 64-bit adds)
//   reset: synchronous active-low i_rst_n empties both registers and puts
//   the parser back to whitespace skipping with a zero accumulator
//   stall: while i_ready is low the result word holds; one more word can
//   wait in the input register, after that o_ready drops
// ----------------------------------------------------------------------------
module content_length_header_parser_top
    import clhp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BYTE_W-1:0]   i_byte_in,
    input  logic                i_stream_fault,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_length
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_fault;
    logic              out_free;
    logic              step_fire;
    t_result           step_res;

    // a held word is parsed once the result register can take its result
    assign step_fire = in_valid && out_free;

    // input register stage
    clhp_in_reg u_in_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_in      (i_byte_in),
        .i_stream_fault (i_stream_fault),
        .i_take         (step_fire),
        .o_valid        (in_valid),
        .o_byte         (in_byte),
        .o_fault        (in_fault)
    );

    // parser state and per-byte decision
    clhp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (step_fire),
        .i_byte  (in_byte),
        .i_fault (in_fault),
        .o_res   (step_res)
    );

    // result register facing the receiver
    clhp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step_fire),
        .i_res    (step_res),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_status (o_status),
        .o_length (o_length)
    );

endmodule

### rtl/core/clhp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clhp_checker
// port-level checks for the content-length parser, bound to the top level
// ----------------------------------------------------------------------------
module clhp_checker
    import clhp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [LEN_W-1:0]    o_length
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_length))
        else $error("result word changed while stalled");

    // length is only carried by a done result
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> o_length == '0)
        else $error("nonzero length on a result that is not done");

    // status codes stay within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_BUSY) || (o_status == ST_DONE) ||
                    (o_status == ST_BAD) || (o_status == ST_LONG) ||
                    (o_status == ST_FAULT))
        else $error("undefined status code");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind content_length_header_parser_top clhp_checker u_clhp_checker (.*);

### tb/content_length_header_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_length_header_parser_top_test
// self-checking bench for the content-length header parser: directed
// whitespace, literal and fault cases, then random well-formed, broken and
// noise headers checked word by word against a local parse model
// ----------------------------------------------------------------------------
module content_length_header_parser_top_test;
    import clhp_pkg::*;

    localparam logic [127:0] HDR_TEXT = "Content-Length: ";
    localparam logic [7:0]   CH_ZERO  = "0";
    localparam logic [7:0]   CH_NINE  = "9";

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_byte_in;
    logic                i_stream_fault;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [LEN_W-1:0]    o_length;

    content_length_header_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_byte_in      (i_byte_in),
        .i_stream_fault (i_stream_fault),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_length       (o_length)
    );

    // parse model state
    t_phase           hdr_phase;
    logic [IDX_W-1:0] hdr_index;
    logic [CNT_W-1:0] hdr_digits;
    logic [LEN_W-1:0] hdr_length;

    t_result pending_results[$];
    int      words_sent;
    int      mismatch_count;
    bit      no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("content_length_header_parser_top: mismatch");
        $finish;
    end

    function automatic logic [7:0] hdr_char(input int idx);
        return HDR_TEXT[8*(15-idx) +: 8];
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void clear_header();
        hdr_phase  = PH_WS;
        hdr_index  = '0;
        hdr_digits = '0;
        hdr_length = '0;
    endfunction

    // one parse step; every word yields exactly one result
    function automatic t_result parse_byte(input logic [7:0] b, input logic fault);
        t_result res;
        res.status = ST_BUSY;
        res.length = '0;
        if (fault) begin
            res.status = ST_FAULT;
        end else begin
            // first non-space byte is checked as literal text right away
            if (hdr_phase == PH_WS && !is_space(b))
                hdr_phase = PH_TEXT;
            case (hdr_phase)
                PH_WS: begin
                end
                PH_TEXT: begin
                    if (hdr_index < LIT_LEN) begin
                        if (b != hdr_char(hdr_index[3:0]))
                            res.status = ST_BAD;
                        else
                            hdr_index = hdr_index + 1'b1;
                    end else if (!is_digit(b)) begin
                        res.status = ST_BAD;
                    end else begin
                        hdr_phase  = PH_DIGITS;
                        hdr_index  = '0;
                        hdr_digits = 5'd1;
                        hdr_length = LEN_W'(b - CH_ZERO);
                    end
                end
                PH_DIGITS: begin
                    if (is_digit(b)) begin
                        if (hdr_digits >= MAX_DIGITS) begin
                            res.status = ST_LONG;
                        end else begin
                            hdr_digits = hdr_digits + 1'b1;
                            hdr_length = hdr_length * 10 + LEN_W'(b - CH_ZERO);
                        end
                    end else if (b == CH_CR) begin
                        hdr_phase = PH_LF;
                    end else begin
                        res.status = ST_BAD;
                    end
                end
                default: begin
                    if (b == CH_LF) begin
                        res.status = ST_DONE;
                        res.length = hdr_length;
                    end else begin
                        res.status = ST_BAD;
                    end
                end
            endcase
        end
        if (res.status != ST_BUSY)
            clear_header();
        return res;
    endfunction

    function automatic void note_mismatch(input string field, input logic [63:0] exp_val,
                                          input logic [63:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected %0d actual %0d", $realtime, field, exp_val, act_val);
    endfunction

    // sends one word; the model is stepped at the edge where it is taken
    task automatic send_word(input logic [7:0] b, input logic fault);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(99) < 17) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid        <= 1'b1;
        i_byte_in      <= b;
        i_stream_fault <= fault;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(parse_byte(b, fault));
        words_sent++;
    endtask

    // receiver stalls at random unless in the quiet stretch
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected word, status", 0, o_status);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status != exp_res.status)
                    note_mismatch("status", exp_res.status, o_status);
                if (o_length != exp_res.length)
                    note_mismatch("length", exp_res.length, o_length);
            end
        end
    end

    task automatic test_leading_whitespace();
        send_word(8'h20, 1'b0);
        send_word(8'h09, 1'b0);
        send_word(8'h0A, 1'b0);
        send_word(8'h0B, 1'b0);
        send_word(8'h0C, 1'b0);
        send_word(8'h0D, 1'b0);
        // neighbors of the space range are not skipped
        send_word(8'h00, 1'b0);
        send_word(8'h08, 1'b0);
        send_word(8'h0E, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_literal_errors();
        send_word("C", 1'b0);
        send_word("o", 1'b0);
        send_word("x", 1'b0);
        send_word("c", 1'b0);
    endtask

    task automatic test_stream_fault();
        send_word(8'hFF, 1'b1);
        send_word(8'h20, 1'b0);
        send_word("C", 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // one header, optionally damaged at a random spot
    task automatic send_header(input bit broken);
        logic [8:0] words[$];
        int         n_space;
        int         n_digit;
        int         mode;
        int         pick;
        int         pos;
        logic [7:0] d;
        n_space = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
        repeat (n_space) begin
            pick = $urandom_range(5);
            words.push_back({1'b0, (pick == 5) ? 8'h20 : 8'(8'h09 + pick)});
        end
        for (int i = 0; i < 16; i++)
            words.push_back({1'b0, hdr_char(i)});
        pick = $urandom_range(99);
        if (pick < 70)
            n_digit = $urandom_range(1, 3);
        else if (pick < 90)
            n_digit = $urandom_range(4, 18);
        else
            n_digit = $urandom_range(19, 21);
        mode = $urandom_range(99);
        for (int i = 0; i < n_digit; i++) begin
            if (mode < 80)
                d = CH_ZERO + 8'($urandom_range(9));
            else if (mode < 90)
                d = CH_NINE;
            else
                d = CH_ZERO;
            words.push_back({1'b0, d});
        end
        words.push_back({1'b0, CH_CR});
        words.push_back({1'b0, CH_LF});
        if (broken) begin
            pos  = $urandom_range(words.size() - 1);
            pick = $urandom_range(3);
            case (pick)
                0: words[pos] = {1'b0, 8'($urandom_range(255))};
                1: words[pos] = {1'b1, 8'($urandom_range(255))};
                2: words.delete(pos);
                default: begin
                    while (words.size() > pos)
                        void'(words.pop_back());
                end
            endcase
        end
        foreach (words[i])
            send_word(words[i][7:0], words[i][8]);
    endtask

    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(99) < 30)
                b = 8'h09 + 8'($urandom_range(4));
            else
                b = 8'($urandom_range(255));
            send_word(b, $urandom_range(99) < 5);
        end
    endtask

    task automatic test_random_traffic(input int n_words);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < n_words) begin
            pick = $urandom_range(99);
            if (pick < 72)
                send_header(1'b0);
            else if (pick < 86)
                send_header(1'b1);
            else
                send_noise();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_byte_in      = '0;
        i_stream_fault = 1'b0;
        no_idle        = 1'b0;
        words_sent     = 0;
        mismatch_count = 0;
        clear_header();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_leading_whitespace();
        test_literal_errors();
        test_stream_fault();
        test_random_traffic(500);
        no_idle = 1'b1;
        test_random_traffic(250);
        no_idle = 1'b0;
        test_random_traffic(400);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("content_length_header_parser_top: match");
        else
            $display("content_length_header_parser_top: mismatch");
        $finish;
    end

endmodule
